// ===== rtl/dpic_pkg.sv =====
// shared types and constants of the door press interlock controller
`default_nettype none
package dpic_pkg;
   localparam int TIME_BITS_DEF = 32;
   localparam int MAX_CMDS = 11;
   localparam int CNT_BITS = 4;

   typedef enum logic [2:0] {
      ST_LOCK = 3'd0, ST_IDLE = 3'd1, ST_READY = 3'd2, ST_RUN = 3'd3,
      ST_EMER = 3'd4, ST_DONE = 3'd5, ST_INIT = 3'd6
   } mode_type;

   typedef enum logic [3:0] {
      C_NONE = 4'd0, C_YELLOW = 4'd1, C_OFF = 4'd2, C_GREEN = 4'd3, C_RED = 4'd4,
      C_OPEN = 4'd5, C_CLOSE = 4'd6, C_LOCK = 4'd7, C_UNLOCK = 4'd8, C_DREADY = 4'd9
   } cmd_type;

   localparam logic [2:0] REG_RISK = 3'd0;
   localparam logic [2:0] REG_ESTOP = 3'd1;
   localparam logic [2:0] REG_INIT_CLOSE = 3'd2;
   localparam logic [2:0] REG_DEBOUNCE = 3'd3;
   localparam logic [2:0] REG_LINK_LIMIT = 3'd4;
   localparam logic [2:0] REG_LOCK_PRESS = 3'd5;
   localparam logic [2:0] REG_CLOSE_CONFIRM = 3'd6;
   localparam logic [2:0] REG_RELEASE_DELAY = 3'd7;

   localparam int LOCK_REARM_MS = 1000;
   localparam int READY_HOLD_MS = 200;
   localparam int OPEN_HOLD_MS = 200;

   typedef struct packed {
      logic       risk_mode;
      logic       estop_active_high;
      logic [15:0] initial_close_ms;
      logic [3:0] debounce_count;
      logic [7:0] link_fail_limit;
      logic [15:0] lock_hold_ms;
      logic [15:0] close_confirm_ms;
      logic [15:0] btn_quiet_ms;
   } cfg_type;
endpackage
`default_nettype wire

// ===== rtl/dpic_engine.sv =====
// one poll of the interlock state machine: next state and command list
`default_nettype none
module dpic_engine import dpic_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire cfg_type         cfg,
   input  wire                  step,
   input  wire [7:0]            in_low,
   input  wire [7:0]            in_high,
   input  wire [7:0]            out_low,
   input  wire                  link_ok,
   input  wire [31:0]           now_ms,
   output cmd_type              cmd_list [MAX_CMDS],
   output logic [CNT_BITS-1:0]  cmd_count,
   output mode_type             mode_out
);
   typedef logic [TIME_BITS-1:0] t_type;
   typedef struct packed { t_type t; logic v; } stamp_type;

   mode_type mode_ff, mode_in;
   logic [7:0] lerr_ff, lerr_in;
   logic lfault_ff, lfault_in;
   logic [3:0] upc_ff, upc_in, dnc_ff, dnc_in;
   logic ups_ff, ups_in, dns_ff, dns_in;
   stamp_type lpt_ff, lpt_in, lrt_ff, lrt_in, rpt_ff, rpt_in, cpt_ff, cpt_in;
   stamp_type opt_ff, opt_in, rel_ff, rel_in, cst_ff, cst_in;
   logic lrel_ff, lrel_in;
   t_type lcm_ff, lcm_in;
   logic cflag_ff, cflag_in, ctop_ff, ctop_in, learned_ff, learned_in;
   logic pconf_ff, pconf_in;

   assign mode_out = mode_ff;

   always_comb begin
      cmd_type   lst [MAX_CMDS];
      logic [CNT_BITS-1:0] n;
      t_type now, close_ms, de, since_c;
      logic up, down, estop, laser, at_bottom_ok, risk_ok, btn, held;
      logic [TIME_BITS+1:0] de3, close2;
      mode_in = mode_ff; lerr_in = lerr_ff; lfault_in = lfault_ff;
      upc_in = upc_ff; dnc_in = dnc_ff; ups_in = ups_ff; dns_in = dns_ff;
      lpt_in = lpt_ff; lrt_in = lrt_ff; rpt_in = rpt_ff; cpt_in = cpt_ff;
      opt_in = opt_ff; rel_in = rel_ff; cst_in = cst_ff; lrel_in = lrel_ff;
      lcm_in = lcm_ff; cflag_in = cflag_ff; ctop_in = ctop_ff;
      learned_in = learned_ff; pconf_in = pconf_ff;
      for (int i = 0; i < MAX_CMDS; i++) lst[i] = C_NONE;
      n = '0;
      now = t_type'(now_ms);
      laser = 1'b0; up = 1'b0; down = 1'b0; estop = 1'b0; btn = 1'b0; held = 1'b0;
      at_bottom_ok = 1'b0; risk_ok = 1'b0; de = '0; de3 = '0; close2 = '0;
      close_ms = learned_ff ? lcm_ff : t_type'(cfg.initial_close_ms);
      since_c = now - cst_ff.t;
      if (!link_ok) begin
         if (lerr_in != 8'd255) lerr_in = lerr_in + 8'd1;
         if (lerr_in >= cfg.link_fail_limit && !lfault_in) begin
            lst[n] = C_YELLOW; n = n + 1'b1;
            lfault_in = 1'b1; lerr_in = '0;
         end
      end else begin
         if (lfault_in) begin lst[n] = C_OFF; n = n + 1'b1; lfault_in = 1'b0; end
         lerr_in = '0;
         if (in_low[0]) begin
            if (upc_in != 4'd15) upc_in = upc_in + 4'd1;
            if (upc_in >= cfg.debounce_count) ups_in = 1'b1;
            dnc_in = '0;
         end else begin upc_in = '0; ups_in = 1'b0; end
         if (in_low[1]) begin
            if (dnc_in != 4'd15) dnc_in = dnc_in + 4'd1;
            if (dnc_in >= cfg.debounce_count) dns_in = 1'b1;
            upc_in = '0;
         end else begin dnc_in = '0; dns_in = 1'b0; end
         up = ups_in; down = dns_in;

         if (mode_in == ST_INIT) mode_in = ST_LOCK;
         if (!out_low[7] && mode_in != ST_EMER) mode_in = ST_LOCK;
         if (mode_in == ST_LOCK && out_low[7]) mode_in = ST_IDLE;
         if (mode_in == ST_IDLE) begin
            if (up || pconf_in) mode_in = out_low[6] ? ST_READY : ST_IDLE;
            else if (down) mode_in = ST_DONE;
         end
         if (mode_in == ST_READY) begin
            if (!out_low[6]) mode_in = ST_IDLE;
            if (out_low[1] && !down) mode_in = ST_RUN;
         end
         if (mode_in == ST_RUN) begin
            at_bottom_ok = out_low[1] && down;
            risk_ok = cfg.risk_mode && out_low[1] && in_low[5] && cst_in.v &&
                      (since_c > close_ms);
            if (at_bottom_ok || risk_ok) begin
               lst[n] = C_GREEN; n = n + 1'b1;
               cflag_in = 1'b0; opt_in.v = 1'b0;
               if (ctop_in && cst_in.v) begin
                  lcm_in = since_c; learned_in = 1'b1; close_ms = since_c;
               end
               ctop_in = 1'b0;
               mode_in = ST_DONE;
            end
         end
         if (mode_in == ST_DONE && out_low[0] && (up || cfg.risk_mode)) begin
            lst[n] = C_OFF; n = n + 1'b1; mode_in = ST_IDLE;
         end
         if (mode_in == ST_EMER) begin
            lst[n] = C_RED; n = n + 1'b1;
            if (in_low[7:5] != 3'b111 && !in_high[0]) mode_in = ST_LOCK;
         end
         estop = cfg.estop_active_high ? in_high[3] : !in_high[3];
         if (estop) begin
            mode_in = ST_EMER;
            if (!up) begin lst[n] = C_OPEN; n = n + 1'b1; end
            lst[n] = C_LOCK; n = n + 1'b1;
         end
         if (in_low[7:5] != 3'b000 || in_high[0]) begin
            de = cst_in.v ? since_c : '0;
            // elapsed beyond floor(2*close/3) is the same as 3*elapsed > 2*close
            de3 = {2'b00, de} + {1'b0, de, 1'b0};
            close2 = {1'b0, close_ms, 1'b0};
            if (learned_in && cflag_in && cst_in.v && !down && de3 > close2) begin
               laser = 1'b1; mode_in = ST_EMER;
               lst[n] = C_OPEN; n = n + 1'b1;
               lst[n] = C_LOCK; n = n + 1'b1;
               cst_in.v = 1'b0; cflag_in = 1'b0;
            end
         end
         if (!estop && !laser) begin
            btn = in_high[2:1] != 2'b00;
            if (in_high[4]) begin
               if (!lpt_in.v) begin lpt_in.t = now; lpt_in.v = 1'b1; end
            end else begin lpt_in.v = 1'b0; lrel_in = 1'b1; end
            if (in_high[4] && (now - lpt_in.t) >= t_type'(cfg.lock_hold_ms) && lrel_in &&
                (!lrt_in.v || (now - lrt_in.t) >= t_type'(LOCK_REARM_MS))) begin
               lst[n] = out_low[7] ? C_LOCK : C_UNLOCK; n = n + 1'b1;
               lpt_in.v = 1'b0; lrel_in = 1'b0;
               lrt_in.t = now; lrt_in.v = 1'b1;
            end
            if (mode_in == ST_IDLE && !pconf_in) begin
               if (up) begin lst[n] = C_OPEN; n = n + 1'b1; pconf_in = 1'b1; end
               else if (down) begin lst[n] = C_CLOSE; n = n + 1'b1; pconf_in = 1'b1; end
            end
            if (mode_in == ST_IDLE) begin
               if (btn && !out_low[1]) begin
                  if (!rpt_in.v) begin rpt_in.t = now; rpt_in.v = 1'b1; end
               end else rpt_in.v = 1'b0;
               if (rpt_in.v && (now - rpt_in.t) >= t_type'(READY_HOLD_MS) && !rel_in.v) begin
                  lst[n] = C_DREADY; n = n + 1'b1;
                  rpt_in.v = 1'b0; pconf_in = 1'b1;
               end
            end
            if (mode_in == ST_READY) begin
               if (btn && !out_low[1] && !rel_in.v) begin
                  if (!cpt_in.v) begin cpt_in.t = now; cpt_in.v = 1'b1; end
               end else cpt_in.v = 1'b0;
               held = cpt_in.v && (now - cpt_in.t) >= t_type'(cfg.close_confirm_ms);
               if (in_high[2:1] == 2'b11 && held && !rel_in.v && !out_low[1]) begin
                  lst[n] = C_CLOSE; n = n + 1'b1;
                  cpt_in.v = 1'b0;
                  rel_in.t = now; rel_in.v = 1'b1;
                  cst_in.t = now; cst_in.v = 1'b1;
                  cflag_in = 1'b1; ctop_in = up;
               end
            end
            if (mode_in == ST_DONE) begin
               if (btn && !out_low[0]) begin
                  if (!opt_in.v) begin opt_in.t = now; opt_in.v = 1'b1; end
               end else opt_in.v = 1'b0;
               held = opt_in.v && (now - opt_in.t) >= t_type'(OPEN_HOLD_MS);
               if (btn && held && !rel_in.v && !out_low[0]) begin
                  lst[n] = C_OPEN; n = n + 1'b1;
                  opt_in.v = 1'b0;
                  rel_in.t = now; rel_in.v = 1'b1;
               end
            end
         end
         if (in_high[2:1] == 2'b00) begin
            if (rel_in.v && (now - rel_in.t) >= t_type'(cfg.btn_quiet_ms))
               rel_in.v = 1'b0;
         end else if (rel_in.v) begin
            rel_in.t = now;
         end
      end
      cmd_list = lst;
      cmd_count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ST_INIT; lerr_ff <= '0; lfault_ff <= 1'b0;
         upc_ff <= '0; dnc_ff <= '0; ups_ff <= 1'b0; dns_ff <= 1'b0;
         lpt_ff <= '0; lrt_ff <= '0; rpt_ff <= '0; cpt_ff <= '0;
         opt_ff <= '0; rel_ff <= '0; cst_ff <= '0; lrel_ff <= 1'b1;
         lcm_ff <= '0; cflag_ff <= 1'b0; ctop_ff <= 1'b0;
         learned_ff <= 1'b0; pconf_ff <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in; lerr_ff <= lerr_in; lfault_ff <= lfault_in;
         upc_ff <= upc_in; dnc_ff <= dnc_in; ups_ff <= ups_in; dns_ff <= dns_in;
         lpt_ff <= lpt_in; lrt_ff <= lrt_in; rpt_ff <= rpt_in; cpt_ff <= cpt_in;
         opt_ff <= opt_in; rel_ff <= rel_in; cst_ff <= cst_in; lrel_ff <= lrel_in;
         lcm_ff <= lcm_in; cflag_ff <= cflag_in; ctop_ff <= ctop_in;
         learned_ff <= learned_in; pconf_ff <= pconf_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/door_press_interlock_controller_core.sv =====
// top level of the door press interlock controller: registers, engine and output queue
`default_nettype none
// path: a poll word waits in the input register until the result buffer is free,
// is evaluated combinationally, and its words drain from that buffer
// throughput: a poll gives one to twelve words; the buffer drains one word a cycle
// while rsp_tready is high, and the next poll is evaluated as its last word leaves
// reset: synchronous, active high; state machine to init, counters and stamps cleared,
// configuration registers to their documented defaults
module door_press_interlock_controller_core import dpic_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [55:0] req_tdata,  // in_low, in_high, out_low, now_ms
   input  wire        req_tuser,  // link_ok
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,  // command, machine_state, pad
   output logic       rsp_tlast,  // last
   input  wire        csr_we,
   input  wire [2:0]  csr_addr,
   input  wire [15:0] csr_wdata
);
   cfg_type cfg_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.risk_mode <= 1'b0;
         cfg_ff.estop_active_high <= 1'b0;
         cfg_ff.initial_close_ms <= 16'd2500;
         cfg_ff.debounce_count <= 4'd3;
         cfg_ff.link_fail_limit <= 8'd10;
         cfg_ff.lock_hold_ms <= 16'd300;
         cfg_ff.close_confirm_ms <= 16'd500;
         cfg_ff.btn_quiet_ms <= 16'd200;
      end else if (csr_we) begin
         case (csr_addr)
            REG_RISK:          cfg_ff.risk_mode <= csr_wdata[0];
            REG_ESTOP:         cfg_ff.estop_active_high <= csr_wdata[0];
            REG_INIT_CLOSE:    cfg_ff.initial_close_ms <= csr_wdata;
            REG_DEBOUNCE:      cfg_ff.debounce_count <= csr_wdata[3:0];
            REG_LINK_LIMIT:    cfg_ff.link_fail_limit <= csr_wdata[7:0];
            REG_LOCK_PRESS:    cfg_ff.lock_hold_ms <= csr_wdata;
            REG_CLOSE_CONFIRM: cfg_ff.close_confirm_ms <= csr_wdata;
            REG_RELEASE_DELAY: cfg_ff.btn_quiet_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic        inv_ff;
   logic [55:0] ind_ff;
   logic        inl_ff;

   // result buffer: command list plus final word, drained one word a cycle while rsp_tready is high
   cmd_type             buf_ff [MAX_CMDS];
   logic [CNT_BITS-1:0] cnt_ff;
   logic [CNT_BITS-1:0] pos_ff;
   logic                busy_ff;

   cmd_type             elist [MAX_CMDS];
   logic [CNT_BITS-1:0] ecount;
   mode_type            emode;
   logic                step;
   logic                drain_done;

   // engine fires when the buffer is free or its last word leaves this cycle
   assign drain_done = busy_ff && rsp_tready && (pos_ff == cnt_ff);
   assign step = inv_ff && (!busy_ff || drain_done);
   assign req_tready = !inv_ff || step;

   dpic_engine #(.TIME_BITS(TIME_BITS)) u_engine (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .step(step),
      .in_low(ind_ff[7:0]), .in_high(ind_ff[15:8]), .out_low(ind_ff[23:16]),
      .link_ok(inl_ff), .now_ms(ind_ff[55:24]),
      .cmd_list(elist), .cmd_count(ecount), .mode_out(emode)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 1'b0;
         busy_ff <= 1'b0;
         pos_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (req_tready) inv_ff <= req_tvalid;
         if (step) begin
            busy_ff <= 1'b1;
            pos_ff <= '0;
            cnt_ff <= ecount;
         end else if (drain_done) begin
            busy_ff <= 1'b0;
         end else if (busy_ff && rsp_tready) begin
            pos_ff <= pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         ind_ff <= req_tdata;
         inl_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (step) buf_ff <= elist;
   end

   logic [CNT_BITS-1:0] sel;
   assign sel = (pos_ff < cnt_ff) ? pos_ff : '0;

   // engine state holds still while a poll drains, so its mode is the poll's final state
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast = (pos_ff == cnt_ff);
   assign rsp_tdata = {1'b0, emode,
                       (pos_ff == cnt_ff) ? C_NONE : buf_ff[sel]};
endmodule
`default_nettype wire

// ===== sim/door_press_interlock_controller_core_tb.sv =====
// testbench of the door press interlock controller core: directed and random polls
`default_nettype none
module door_press_interlock_controller_core_tb;
   import dpic_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   wire         req_tready;
   logic [55:0] req_tdata = 0;   // in_low, in_high, out_low, now_ms
   logic        req_tuser = 0;   // link_ok
   wire         rsp_tvalid;
   logic        rsp_tready = 0;
   wire  [7:0]  rsp_tdata;       // command, machine_state, pad
   wire         rsp_tlast;       // last
   logic        csr_we = 0;
   logic [2:0]  csr_addr = 0;
   logic [15:0] csr_wdata = 0;

   door_press_interlock_controller_core dut (.*);

   always #4 clock = ~clock;

   typedef struct packed {
      cmd_type  cmd;
      mode_type mode;
      logic     last;
   } word_type;

   word_type expected_words[$];
   int       errors = 0;
   int       cycles = 0;
   bit       idle_on = 1;
   bit       hold_rsp = 0;
   int       rsp_idle_left = 0;

   // configuration copy
   logic        cf_risk, cf_estop_hi;
   logic [15:0] cf_init_close, cf_lock_press, cf_close_confirm, cf_release_delay;
   logic [3:0]  cf_debounce;
   logic [7:0]  cf_link_limit;

   // predictor state
   mode_type    p_mode;
   int unsigned p_link_err, p_up_cnt, p_down_cnt;
   bit          p_faulted, p_up_st, p_down_st, p_lock_released;
   bit [31:0]   t_lock_press, t_lock_rel, t_ready, t_close_press, t_open, t_release, t_close_start;
   bit          v_lock_press, v_lock_rel, v_ready, v_close_press, v_open, v_release, v_close_start;
   bit [31:0]   p_learned;
   bit          p_closing, p_from_top, p_learned_ok, p_pos_ok;
   cmd_type     poll_cmds[$];

   // simulated millisecond clock for stimulus
   bit [31:0]   ms_now;

   function automatic void predictor_reset();
      cf_risk = 0; cf_estop_hi = 0; cf_init_close = 2500; cf_debounce = 3;
      cf_link_limit = 10; cf_lock_press = 300; cf_close_confirm = 500; cf_release_delay = 200;
      p_mode = ST_INIT; p_link_err = 0; p_faulted = 0;
      p_up_cnt = 0; p_down_cnt = 0; p_up_st = 0; p_down_st = 0; p_lock_released = 1;
      {v_lock_press, v_lock_rel, v_ready, v_close_press, v_open, v_release, v_close_start} = 0;
      {t_lock_press, t_lock_rel, t_ready, t_close_press, t_open, t_release, t_close_start} = 0;
      p_learned = 2500;
      p_closing = 0; p_from_top = 0; p_learned_ok = 0; p_pos_ok = 0;
   endfunction

   function automatic void add_cmd(cmd_type c);
      if (poll_cmds.size() < MAX_CMDS) poll_cmds.push_back(c);
   endfunction

   // evaluate one poll and queue its words
   function automatic void predict_poll(bit [7:0] lo, bit [7:0] hi, bit [7:0] ol, bit ok,
                                        bit [31:0] now);
      bit [31:0] close_ms, de, lim;
      bit up, down, estop, laser, at_bottom_ok, risk_ok, btn, held;
      laser = 0;
      poll_cmds.delete();
      if (!ok) begin
         if (p_link_err < 255) p_link_err++;
         if (p_link_err >= cf_link_limit && !p_faulted) begin
            add_cmd(C_YELLOW); p_faulted = 1; p_link_err = 0;
         end
      end else begin
         if (p_faulted) begin add_cmd(C_OFF); p_faulted = 0; end
         p_link_err = 0;
         if (lo[0]) begin
            if (p_up_cnt < 15) p_up_cnt++;
            if (p_up_cnt >= cf_debounce) p_up_st = 1;
            p_down_cnt = 0;
         end else begin p_up_cnt = 0; p_up_st = 0; end
         if (lo[1]) begin
            if (p_down_cnt < 15) p_down_cnt++;
            if (p_down_cnt >= cf_debounce) p_down_st = 1;
            p_up_cnt = 0;
         end else begin p_down_cnt = 0; p_down_st = 0; end
         up = p_up_st; down = p_down_st;
         close_ms = p_learned_ok ? p_learned : 32'(cf_init_close);

         if (p_mode == ST_INIT) p_mode = ST_LOCK;
         if (!ol[7] && p_mode != ST_EMER) p_mode = ST_LOCK;
         if (p_mode == ST_LOCK && ol[7]) p_mode = ST_IDLE;
         if (p_mode == ST_IDLE) begin
            if (up || p_pos_ok) p_mode = ol[6] ? ST_READY : ST_IDLE;
            else if (down) p_mode = ST_DONE;
         end
         if (p_mode == ST_READY) begin
            if (!ol[6]) p_mode = ST_IDLE;
            if (ol[1] && !down) p_mode = ST_RUN;
         end
         if (p_mode == ST_RUN) begin
            at_bottom_ok = ol[1] && down;
            risk_ok = cf_risk && ol[1] && lo[5] && v_close_start &&
                      (now - t_close_start) > close_ms;
            if (at_bottom_ok || risk_ok) begin
               add_cmd(C_GREEN);
               p_closing = 0; v_open = 0;
               if (p_from_top && v_close_start) begin
                  p_learned = now - t_close_start;
                  p_learned_ok = 1;
                  close_ms = p_learned;
               end
               p_from_top = 0;
               p_mode = ST_DONE;
            end
         end
         if (p_mode == ST_DONE && ol[0] && (up || cf_risk)) begin
            add_cmd(C_OFF); p_mode = ST_IDLE;
         end
         if (p_mode == ST_EMER) begin
            add_cmd(C_RED);
            if (lo[7:5] != 3'b111 && !hi[0]) p_mode = ST_LOCK;
         end

         estop = cf_estop_hi ? hi[3] : !hi[3];
         if (estop) begin
            p_mode = ST_EMER;
            if (!up) add_cmd(C_OPEN);
            add_cmd(C_LOCK);
         end
         // late-close light curtain
         if (lo[7:5] != 0 || hi[0]) begin
            de = v_close_start ? now - t_close_start : 0;
            lim = (close_ms / 3) * 2 + ((close_ms % 3) * 2) / 3;
            if (p_learned_ok && p_closing && v_close_start && !down && de > lim) begin
               laser = 1; p_mode = ST_EMER;
               add_cmd(C_OPEN); add_cmd(C_LOCK);
               v_close_start = 0; p_closing = 0;
            end
         end

         if (!estop && !laser) begin
            btn = hi[2:1] != 0;
            if (hi[4]) begin
               if (!v_lock_press) begin t_lock_press = now; v_lock_press = 1; end
            end else begin v_lock_press = 0; p_lock_released = 1; end
            if (hi[4] && (now - t_lock_press) >= cf_lock_press && p_lock_released &&
                (!v_lock_rel || (now - t_lock_rel) >= LOCK_REARM_MS)) begin
               add_cmd(ol[7] ? C_LOCK : C_UNLOCK);
               v_lock_press = 0; p_lock_released = 0;
               t_lock_rel = now; v_lock_rel = 1;
            end
            if (p_mode == ST_IDLE && !p_pos_ok) begin
               if (up) begin add_cmd(C_OPEN); p_pos_ok = 1; end
               else if (down) begin add_cmd(C_CLOSE); p_pos_ok = 1; end
            end
            if (p_mode == ST_IDLE) begin
               if (btn && !ol[1]) begin
                  if (!v_ready) begin t_ready = now; v_ready = 1; end
               end else v_ready = 0;
               if (v_ready && (now - t_ready) >= READY_HOLD_MS && !v_release) begin
                  add_cmd(C_DREADY); v_ready = 0; p_pos_ok = 1;
               end
            end
            if (p_mode == ST_READY) begin
               if (btn && !ol[1] && !v_release) begin
                  if (!v_close_press) begin t_close_press = now; v_close_press = 1; end
               end else v_close_press = 0;
               held = v_close_press && (now - t_close_press) >= cf_close_confirm;
               if (hi[2:1] == 2'b11 && held && !v_release && !ol[1]) begin
                  add_cmd(C_CLOSE); v_close_press = 0;
                  t_release = now; v_release = 1;
                  t_close_start = now; v_close_start = 1;
                  p_closing = 1; p_from_top = up;
               end
            end
            if (p_mode == ST_DONE) begin
               if (btn && !ol[0]) begin
                  if (!v_open) begin t_open = now; v_open = 1; end
               end else v_open = 0;
               held = v_open && (now - t_open) >= OPEN_HOLD_MS;
               if (btn && held && !v_release && !ol[0]) begin
                  add_cmd(C_OPEN); v_open = 0;
                  t_release = now; v_release = 1;
               end
            end
         end
         if (hi[2:1] == 0) begin
            if (v_release && (now - t_release) >= cf_release_delay) v_release = 0;
         end else if (v_release) t_release = now;
      end
      foreach (poll_cmds[k]) expected_words.push_back(word_type'{poll_cmds[k], p_mode, 1'b0});
      expected_words.push_back(word_type'{C_NONE, p_mode, 1'b1});
   endfunction

   // result checker
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word cmd=%0d state=%0d last=%0b", $time,
                     rsp_tdata[3:0], rsp_tdata[6:4], rsp_tlast);
            errors <= errors + 1;
         end else begin
            word_type w;
            w = expected_words.pop_front();
            if (rsp_tdata[3:0] !== w.cmd || rsp_tdata[6:4] !== w.mode ||
                rsp_tlast !== w.last || rsp_tdata[7] !== 1'b0) begin
               $display("%0t: mismatch expected cmd=%0d state=%0d last=%0b, got cmd=%0d state=%0d last=%0b",
                        $time, w.cmd, w.mode, w.last, rsp_tdata[3:0], rsp_tdata[6:4], rsp_tlast);
               errors <= errors + 1;
            end
         end
      end
   end

   // receiver stalls in random bursts, plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_rsp) rsp_tready <= 0;
      else if (rsp_idle_left > 0) begin
         rsp_tready <= 0;
         rsp_idle_left <= rsp_idle_left - 1;
      end else if (idle_on && rsp_tready && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 0;
         rsp_idle_left <= $urandom_range(0, 2);
      end else rsp_tready <= 1;
   end

   // timeout guard
   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_poll(bit [7:0] lo, bit [7:0] hi, bit [7:0] ol, bit ok, bit [31:0] now);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {now, ol, hi, lo};
      req_tuser <= ok;
      predict_poll(lo, hi, ol, ok, now);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         REG_RISK:          cf_risk = val[0];
         REG_ESTOP:         cf_estop_hi = val[0];
         REG_INIT_CLOSE:    cf_init_close = val;
         REG_DEBOUNCE:      cf_debounce = val[3:0];
         REG_LINK_LIMIT:    cf_link_limit = val[7:0];
         REG_LOCK_PRESS:    cf_lock_press = val;
         REG_CLOSE_CONFIRM: cf_close_confirm = val;
         REG_RELEASE_DELAY: cf_release_delay = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // estop released: bit3 set when active low
   function automatic bit [7:0] safe_hi(bit [7:0] hi);
      return cf_estop_hi ? (hi & 8'hF7) : (hi | 8'h08);
   endfunction

   // one poll dt ms on
   task automatic step(bit [7:0] lo, bit [7:0] hi, bit [7:0] ol, int dt);
      ms_now += dt;
      send_poll(lo, hi, ol, 1'b1, ms_now);
   endtask

   task automatic test_directed();
      // extremes and link faults
      send_poll(8'h00, 8'h00, 8'h00, 1'b0, 32'h0);
      send_poll(8'hFF, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
      send_poll(8'hFF, 8'hFF, 8'hFF, 1'b0, 32'hFFFF_FFFF);
      repeat (10) send_poll(8'h00, 8'h00, 8'h00, 1'b0, 32'h5);
      ms_now = 32'hFFFF_FF00;  // time wrap through the sequence
      // powered, door up, confirm position
      repeat (4) step(8'h01, safe_hi(8'h00), 8'h80, 10);
      // lock button press and hold
      step(8'h01, safe_hi(8'h10), 8'h80, 10);
      step(8'h01, safe_hi(8'h10), 8'h80, 400);
      step(8'h01, safe_hi(8'h00), 8'h80, 10);
      // ready, then close hold
      step(8'h01, safe_hi(8'h06), 8'hC0, 10);
      step(8'h01, safe_hi(8'h06), 8'hC0, 600);
      step(8'h01, safe_hi(8'h06), 8'hC0, 600);
      step(8'h01, safe_hi(8'h00), 8'hC0, 300);
      step(8'h00, safe_hi(8'h00), 8'hC2, 300);
      repeat (3) step(8'h02, safe_hi(8'h00), 8'hC2, 300);
      // open from done
      step(8'h02, safe_hi(8'h02), 8'h80, 10);
      step(8'h02, safe_hi(8'h02), 8'h80, 300);
      // estop and laser
      step(8'h00, safe_hi(8'h00) ^ 8'h08, 8'h80, 10);
      step(8'hE0, safe_hi(8'h01), 8'h80, 10);
      step(8'h00, safe_hi(8'h00), 8'h80, 10);
   endtask

   // well-formed cycles with random timing, plus noise
   task automatic test_random(int polls);
      bit [7:0] lo, hi, ol;
      int phase;
      phase = 0;
      for (int i = 0; i < polls; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_poll(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                      ms_now + $urandom_range(0, 5000));
            continue;
         end
         phase = (phase + ($urandom_range(0, 5) == 0 ? 1 : 0)) % 5;
         case (phase)
            0: begin lo = 8'h01; hi = 8'h00; ol = 8'h80; end
            1: begin lo = 8'h01; hi = 8'h06; ol = 8'hC0; end
            2: begin lo = 8'h00; hi = 8'h00; ol = 8'hC2; end
            3: begin lo = 8'h02; hi = 8'h02; ol = 8'h82; end
            default: begin lo = 8'h02; hi = 8'h04; ol = 8'h81; end
         endcase
         if ($urandom_range(0, 7) == 0) hi |= 8'h10;
         if ($urandom_range(0, 11) == 0) lo |= 8'($urandom_range(1, 7) << 5);
         if ($urandom_range(0, 15) == 0) hi |= 8'h01;
         hi = safe_hi(hi);
         if ($urandom_range(0, 30) == 0) hi ^= 8'h08;
         hi |= 8'($urandom_range(0, 7) << 5);
         ol |= 8'($urandom_range(0, 3) << 2);
         ms_now += $urandom_range(1, 700);
         send_poll(lo, hi, ol, $urandom_range(0, 20) != 0, ms_now);
      end
   endtask

   // receiver held off while polls keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (150) @(negedge clock);
            hold_rsp = 0;
         end
         test_random(30);
      join
   endtask

   initial begin
      predictor_reset();
      ms_now = 0;
      repeat (7) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      test_directed();
      drain();

      // risky settings at the extremes
      write_reg(REG_RISK, 16'd1);
      write_reg(REG_ESTOP, 16'd1);
      write_reg(REG_INIT_CLOSE, 16'd1);
      write_reg(REG_DEBOUNCE, 16'd1);
      write_reg(REG_LINK_LIMIT, 16'd1);
      write_reg(REG_LOCK_PRESS, 16'd1);
      write_reg(REG_CLOSE_CONFIRM, 16'd1);
      write_reg(REG_RELEASE_DELAY, 16'd1);
      test_random(120);
      test_backpressure();
      drain();

      write_reg(REG_RISK, 16'd0);
      write_reg(REG_ESTOP, 16'd0);
      write_reg(REG_INIT_CLOSE, 16'hFFFF);
      write_reg(REG_DEBOUNCE, 16'd15);
      write_reg(REG_LINK_LIMIT, 16'd255);
      write_reg(REG_LOCK_PRESS, 16'hFFFF);
      write_reg(REG_CLOSE_CONFIRM, 16'hFFFF);
      write_reg(REG_RELEASE_DELAY, 16'hFFFF);
      test_random(80);
      drain();

      write_reg(REG_RISK, 16'd1);
      write_reg(REG_INIT_CLOSE, 16'd900);
      write_reg(REG_DEBOUNCE, 16'd2);
      write_reg(REG_LINK_LIMIT, 16'd3);
      write_reg(REG_LOCK_PRESS, 16'd250);
      write_reg(REG_CLOSE_CONFIRM, 16'd400);
      write_reg(REG_RELEASE_DELAY, 16'd150);
      test_random(120);
      // last stretch without idling
      idle_on = 0;
      test_random(90);

      req_tvalid <= 0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
